### design/leb_pkg.sv
// Shared types and constants for the line edit buffer.
// Used by leb_cell and line_edit_buffer_core; depends on nothing.
package leb_pkg;

    localparam int CHAR_W   = 8;
    localparam int CARET_W  = 7;
    localparam int RIDX_W   = 6;
    localparam int OP_W     = 3;
    localparam int CFG_W    = 32;
    localparam int CFG_AW   = 3;

    localparam logic [CARET_W-1:0] MAX_LEN_RESET = 7'd64;
    localparam logic [CHAR_W-1:0]  CHAR_LOW      = 8'd32;
    localparam logic [CHAR_W-1:0]  CHAR_HIGH     = 8'd126;

    // Register index of max_length, taken from paddr[2]
    localparam logic REG_MAX_LENGTH = 1'b0;

    // Key event codes
    typedef enum logic [OP_W-1:0] {
        OP_LEFT      = 3'd0,
        OP_RIGHT     = 3'd1,
        OP_HOME      = 3'd2,
        OP_END       = 3'd3,
        OP_BACKSPACE = 3'd4,
        OP_DELETE    = 3'd5,
        OP_CHAR      = 3'd6,
        OP_READ      = 3'd7
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ROTATE,
        ST_FINISH
    } state_t;

    // Command broadcast to every cell of the row
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t           cmd;
        logic [CARET_W-1:0]  pos;
        logic [CHAR_W-1:0]   ch;
    } cell_ctrl_t;

endpackage

### design/line_edit_buffer_core.sv
// Top level of the line edit buffer: sequencer, caret/length state, APB register.
// Depends on leb_pkg and leb_cell (a ring of BUFFER_DEPTH cells).
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-------------------------------------------
//  s_*      | in  | s_tvalid/s_tready| key event: tuser op, tdata char/ctrl/index
//  m_*      | out | m_tvalid/m_tready| result: changed, caret, length, char
//  apb      | in  | psel/penable     | max_length register at address 0
//
// An edit (move, backspace, delete, insert) is accepted, then executed (backspace,
// delete and insert shift the whole cell row in parallel), then its result is loaded.
// A read is accepted, then the ring is rotated once around and cell 0 is sampled at
// the requested index, then its result is loaded. One item is in work at a time;
// a loaded result waits in the output register while the next item is accepted
// and worked, and a result that cannot be loaded stalls the input.
// Reset clears caret, length and control; the text cells are not reset.
module line_edit_buffer_core
    import leb_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    // s_tdata: char_in[7:0], ctrl_held[8], read_index[14:9], zero[15]
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,
    // s_tuser: op[2:0]
    input  logic [OP_W-1:0]   s_tuser,
    // m_tdata: changed[0], caret_out[7:1], length_out[14:8], char_out[22:15], zero[23]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    localparam int IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int RW = (IW > RIDX_W) ? IW : RIDX_W;
    localparam logic [IW-1:0] CNT_LAST = IW'(BUFFER_DEPTH - 1);

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [CHAR_W-1:0]    ch_reg, ch_next;
    logic                 ctrl_reg, ctrl_next;
    logic [RIDX_W-1:0]    ridx_reg, ridx_next;
    logic [IW-1:0]        cnt_reg, cnt_next;
    logic [CARET_W-1:0]   caret_reg, caret_next;
    logic [CARET_W-1:0]   length_reg, length_next;
    logic                 changed_reg, changed_next;
    logic [CHAR_W-1:0]    rchar_reg, rchar_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [23:0]          m_tdata_reg, m_tdata_next;
    logic [CARET_W-1:0]   max_length_reg;

    cell_ctrl_t           cell_ctrl;
    logic [CHAR_W-1:0]    cell_char [BUFFER_DEPTH];
    logic                 out_free;
    logic                 cfg_write;
    logic                 char_ok;
    logic                 room_ok;

    // ------------------------------------------------------------------
    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_length_reg <= MAX_LEN_RESET;
        else if (cfg_write && paddr[2] == REG_MAX_LENGTH)
            max_length_reg <= pwdata[CARET_W-1:0];
    end

    always_comb
    begin
        if (paddr[2] == REG_MAX_LENGTH)
            prdata = {{(CFG_W-CARET_W){1'b0}}, max_length_reg};
        else
            prdata = '0;
    end

    // ------------------------------------------------------------------
    // Cell ring
    for (genvar i = 0; i < BUFFER_DEPTH; i++)
    begin : g_cell
        leb_cell #(
            .POS (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .left_char  (cell_char[(i + BUFFER_DEPTH - 1) % BUFFER_DEPTH]),
            .right_char (cell_char[(i + 1) % BUFFER_DEPTH]),
            .char_q     (cell_char[i])
        );
    end

    // ------------------------------------------------------------------
    // Next state
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = (op_t'(s_tuser) == OP_READ) ? ST_ROTATE : ST_EXEC;
            end
            ST_EXEC:
                state_next = ST_FINISH;
            ST_ROTATE:
            begin
                if (cnt_reg == CNT_LAST)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    assign char_ok = !ctrl_reg && ch_reg >= CHAR_LOW && ch_reg <= CHAR_HIGH;
    assign room_ok = (length_reg < max_length_reg) && (int'(length_reg) < BUFFER_DEPTH);

    always_comb
    begin
        op_next       = op_reg;
        ch_next       = ch_reg;
        ctrl_next     = ctrl_reg;
        ridx_next     = ridx_reg;
        cnt_next      = cnt_reg;
        caret_next    = caret_reg;
        length_next   = length_reg;
        changed_next  = changed_reg;
        rchar_next    = rchar_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cell_ctrl     = '{cmd: CELL_HOLD, pos: '0, ch: '0};
        s_tready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next      = op_t'(s_tuser);
                    ch_next      = s_tdata[7:0];
                    ctrl_next    = s_tdata[8];
                    ridx_next    = s_tdata[14:9];
                    cnt_next     = '0;
                    changed_next = 1'b0;
                    rchar_next   = '0;
                end
            end
            ST_EXEC:
            begin
                case (op_reg)
                    OP_LEFT:
                    begin
                        if (caret_reg != '0)
                            caret_next = caret_reg - 1'b1;
                    end
                    OP_RIGHT:
                    begin
                        if (caret_reg < length_reg)
                            caret_next = caret_reg + 1'b1;
                    end
                    OP_HOME:
                        caret_next = '0;
                    OP_END:
                        caret_next = length_reg;
                    OP_BACKSPACE:
                    begin
                        if (caret_reg != '0 && caret_reg <= length_reg)
                        begin
                            cell_ctrl    = '{cmd: CELL_REMOVE, pos: caret_reg - 1'b1,
                                             ch: '0};
                            caret_next   = caret_reg - 1'b1;
                            length_next  = length_reg - 1'b1;
                            changed_next = 1'b1;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (caret_reg < length_reg)
                        begin
                            cell_ctrl    = '{cmd: CELL_REMOVE, pos: caret_reg, ch: '0};
                            length_next  = length_reg - 1'b1;
                            changed_next = 1'b1;
                        end
                    end
                    OP_CHAR:
                    begin
                        if (char_ok && room_ok && caret_reg <= length_reg)
                        begin
                            cell_ctrl    = '{cmd: CELL_INSERT, pos: caret_reg, ch: ch_reg};
                            caret_next   = caret_reg + 1'b1;
                            length_next  = length_reg + 1'b1;
                            changed_next = 1'b1;
                        end
                    end
                    default:
                        cell_ctrl = '{cmd: CELL_HOLD, pos: '0, ch: '0};
                endcase
            end
            ST_ROTATE:
            begin
                // cell 0 holds the character originally at index cnt_reg
                cell_ctrl = '{cmd: CELL_ROTATE, pos: '0, ch: '0};
                if (RW'(cnt_reg) == RW'(ridx_reg) && {1'b0, ridx_reg} < length_reg)
                    rchar_next = cell_char[0];
                cnt_next = cnt_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, rchar_reg, length_reg, caret_reg, changed_reg};
                end
            end
            default:
                s_tready = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            caret_reg    <= '0;
            length_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            caret_reg    <= caret_next;
            length_reg   <= length_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        ch_reg      <= ch_next;
        ctrl_reg    <= ctrl_next;
        ridx_reg    <= ridx_next;
        cnt_reg     <= cnt_next;
        changed_reg <= changed_next;
        rchar_reg   <= rchar_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    a_caret_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        caret_reg <= length_reg)
        else $error("caret beyond text length");

    a_length_fits: assert property (@(posedge clk) disable iff (!rst_n)
        int'(length_reg) <= BUFFER_DEPTH)
        else $error("text length beyond buffer depth");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in work");

    a_rotate_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROTATE && cnt_reg != CNT_LAST) |=>
        (state_reg == ST_ROTATE && cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("rotation stopped early");

endmodule

### design/leb_cell.sv
// One character cell of the text row; trades data with both neighbors.
// Depends on leb_pkg for the cell command struct.
module leb_cell
    import leb_pkg::*;
#(
    parameter int POS = 0
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [CHAR_W-1:0] left_char,
    input  logic [CHAR_W-1:0] right_char,
    output logic [CHAR_W-1:0] char_q
);

    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;

    // insert: cells past the caret take from the left, the caret cell takes the key
    // remove: cells at or past the hole take from the right
    // rotate: whole ring steps toward cell 0
    always_comb
    begin
        char_next = char_reg;
        case (ctrl.cmd)
            CELL_INSERT:
            begin
                if (int'(ctrl.pos) < POS)
                    char_next = left_char;
                else if (int'(ctrl.pos) == POS)
                    char_next = ctrl.ch;
            end
            CELL_REMOVE:
            begin
                if (int'(ctrl.pos) <= POS)
                    char_next = right_char;
            end
            CELL_ROTATE:
                char_next = right_char;
            default:
                char_next = char_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign char_q = char_reg;

endmodule
